// ===== rtl/resbn_pkg.sv =====
// Package: word types, stored entry type and sizing defaults for the record sorter.
package resbn_pkg;

	localparam int unsigned RECORDS_DEF = 8;

	localparam int unsigned HEAD_W = 64;
	localparam int unsigned TAIL_W = 8;
	localparam int unsigned TAG_W  = 3;

	// Input word: one record of the batch.
	typedef struct packed {
		logic [HEAD_W-1:0] key_head;
		logic [TAIL_W-1:0] key_tail;
		logic [TAG_W-1:0]  record_tag;
		logic              last_record;
	} rec_in_t;

	// Output word: one record in sorted order.
	typedef struct packed {
		logic [HEAD_W-1:0] sorted_head;
		logic [TAIL_W-1:0] sorted_tail;
		logic [TAG_W-1:0]  sorted_tag;
		logic              final_out;
	} rec_out_t;

	// Record as held in the batch memory.
	typedef struct packed {
		logic [HEAD_W-1:0] head;
		logic [TAIL_W-1:0] tail;
		logic [TAG_W-1:0]  tag;
	} rec_entry_t;

endpackage

// ===== rtl/record_exchange_sort_by_name.sv =====
// Top level: batch record sorter that orders records by a 9-byte name key.
//
//   channel  signals                            direction  carries
//   rec      rec_valid / rec_ready / rec        in         one record per word
//   sorted   sorted_valid / sorted_ready / sorted  out     one sorted record per word
//
// The block accepts one word per cycle while it sits in its load state.
// The word flagged last_record starts the sort; the block is not ready until
// the whole batch has been emitted. With two or more stored records the sort
// runs on the single key comparator and the single write port of the batch
// memory. Emission reads each record, loads it into the output register and
// holds it there until the consumer takes it. A stall on the sorted channel
// simply holds the output register. Reset empties the batch and returns to
// the load state.
module record_exchange_sort_by_name #(
	parameter int unsigned RECORDS = resbn_pkg::RECORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_valid,
	output logic               rec_ready,
	input  resbn_pkg::rec_in_t rec,
	output logic               sorted_valid,
	input  logic               sorted_ready,
	output resbn_pkg::rec_out_t sorted
);
	import resbn_pkg::*;

	// Index width addresses the memory; count width can also hold RECORDS itself.
	localparam int unsigned IDX_W = (RECORDS > 1) ? $clog2(RECORDS) : 1;
	localparam int unsigned CNT_W = $clog2(RECORDS + 1);

	// The sequencer walks the classic exchange sort: record i is held in a
	// register while every later record j is streamed past the comparator.
	typedef enum logic [7:0] {
		S_LOAD      = 8'b0000_0001,
		S_FETCH_I   = 8'b0000_0010,
		S_HOLD_I    = 8'b0000_0100,
		S_CMP       = 8'b0000_1000,
		S_WB_I      = 8'b0001_0000,
		S_EMIT_RD   = 8'b0010_0000,
		S_EMIT_LD   = 8'b0100_0000,
		S_EMIT_WAIT = 8'b1000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic [CNT_W-1:0]  n_q, n_d;
	logic [IDX_W-1:0]  i_q, i_d;
	logic [IDX_W-1:0]  j_q, j_d;
	logic [IDX_W-1:0]  k_q, k_d;
	logic              out_valid_q, out_valid_d;

	rec_entry_t        cur_q, cur_d;
	rec_entry_t        rdata_q;
	rec_out_t          out_q, out_d;

	// Batch memory: one write port and one registered read port.
	rec_entry_t        rec_mem_q [RECORDS];
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	rec_entry_t        mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;

	logic              accept;
	logic              greater;
	logic [CNT_W-1:0]  n_last;
	logic [CNT_W-1:0]  fill_next;
	logic [IDX_W-1:0]  i_next;

	assign accept    = rec_valid && rec_ready;
	assign rec_ready = (state_q == S_LOAD);
	assign n_last    = n_q - CNT_W'(1);
	assign fill_next = (fill_q < CNT_W'(RECORDS)) ? fill_q + CNT_W'(1) : fill_q;
	assign i_next    = i_q + IDX_W'(1);

	// Unsigned key compare over head then tail, first byte most significant.
	assign greater = {cur_q.head, cur_q.tail} > {rdata_q.head, rdata_q.tail};

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		n_d         = n_q;
		i_d         = i_q;
		j_d         = j_q;
		k_d         = k_q;
		out_valid_d = out_valid_q;
		cur_d       = cur_q;
		out_d       = out_q;
		mem_we      = 1'b0;
		mem_waddr   = i_q;
		mem_wdata   = cur_q;
		mem_raddr   = i_q;

		unique case (state_q)
			S_LOAD: begin
				if (accept) begin
					// Records beyond capacity are dropped, a last one still sorts.
					if (fill_q < CNT_W'(RECORDS)) begin
						mem_we    = 1'b1;
						mem_waddr = fill_q[IDX_W-1:0];
						mem_wdata = '{head: rec.key_head, tail: rec.key_tail,
							tag: rec.record_tag};
					end
					fill_d = fill_next;
					if (rec.last_record) begin
						n_d = fill_next;
						i_d = '0;
						k_d = '0;
						if (fill_next > CNT_W'(1)) begin
							state_d = S_FETCH_I;
						end else begin
							state_d = S_EMIT_RD;
						end
					end
				end
			end
			S_FETCH_I: begin
				mem_raddr = i_q;
				state_d   = S_HOLD_I;
			end
			S_HOLD_I: begin
				// Record i arrives; start streaming from j = i + 1.
				cur_d     = rdata_q;
				j_d       = i_next;
				mem_raddr = i_next;
				state_d   = S_CMP;
			end
			S_CMP: begin
				if (greater) begin
					mem_we    = 1'b1;
					mem_waddr = j_q;
					mem_wdata = cur_q;
					cur_d     = rdata_q;
				end
				if (CNT_W'(j_q) == n_last) begin
					state_d = S_WB_I;
				end else begin
					j_d       = j_q + IDX_W'(1);
					mem_raddr = j_q + IDX_W'(1);
				end
			end
			S_WB_I: begin
				// The smallest remaining record settles at position i.
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = cur_q;
				if (CNT_W'(i_next) == n_last) begin
					k_d     = '0;
					state_d = S_EMIT_RD;
				end else begin
					i_d       = i_next;
					mem_raddr = i_next;
					state_d   = S_HOLD_I;
				end
			end
			S_EMIT_RD: begin
				mem_raddr = k_q;
				state_d   = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				out_d.sorted_head = rdata_q.head;
				out_d.sorted_tail = rdata_q.tail;
				out_d.sorted_tag  = rdata_q.tag;
				out_d.final_out   = (CNT_W'(k_q) == n_last);
				out_valid_d       = 1'b1;
				state_d           = S_EMIT_WAIT;
			end
			S_EMIT_WAIT: begin
				if (sorted_ready) begin
					out_valid_d = 1'b0;
					if (out_q.final_out) begin
						fill_d  = '0;
						state_d = S_LOAD;
					end else begin
						k_d       = k_q + IDX_W'(1);
						mem_raddr = k_q + IDX_W'(1);
						state_d   = S_EMIT_LD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			fill_q      <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			n_q         <= n_d;
			i_q         <= i_d;
			j_q         <= j_d;
			k_q         <= k_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		out_q <= out_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rec_mem_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= rec_mem_q[mem_raddr];
	end

	assign sorted_valid = out_valid_q;
	assign sorted       = out_q;

endmodule

// ===== tb/sort_order_monitor.sv =====
// Monitor that rebuilds each record batch, predicts its sorted order and checks the emitted words.
`timescale 1ns / 100ps
module sort_order_monitor #(
	parameter int unsigned RECORDS = resbn_pkg::RECORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	input  logic                rec_ready,
	input  resbn_pkg::rec_in_t  rec,
	input  logic                sorted_valid,
	input  logic                sorted_ready,
	input  resbn_pkg::rec_out_t sorted,
	output int                  mismatches,
	output int                  words_due,
	output int                  words_checked
);
	import resbn_pkg::*;

	rec_entry_t batch_held [RECORDS];
	int         held_count;
	rec_out_t   sorted_due [$];

	initial begin
		mismatches    = 0;
		words_due     = 0;
		words_checked = 0;
		held_count    = 0;
	end

	// Orders the held batch with the exchange sort and queues one word per position.
	task automatic release_batch();
		rec_entry_t swap;
		for (int i = 0; i + 1 < held_count; i++)
			for (int j = i + 1; j < held_count; j++)
				if ({batch_held[i].head, batch_held[i].tail} >
				    {batch_held[j].head, batch_held[j].tail}) begin
					swap          = batch_held[i];
					batch_held[i] = batch_held[j];
					batch_held[j] = swap;
				end
		for (int i = 0; i < held_count; i++)
			sorted_due.push_back(rec_out_t'{sorted_head: batch_held[i].head,
			                                sorted_tail: batch_held[i].tail,
			                                sorted_tag:  batch_held[i].tag,
			                                final_out:   (i == held_count - 1)});
		held_count = 0;
	endtask

	task automatic compare_field(input string field, input logic [63:0] want,
	                             input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		rec_out_t want;
		if (arst_n) begin
			if (rec_valid && rec_ready) begin
				// Records past the capacity are dropped, but a dropped last word still closes the batch.
				if (held_count < RECORDS) begin
					batch_held[held_count] = '{head: rec.key_head, tail: rec.key_tail,
					                           tag: rec.record_tag};
					held_count++;
				end
				if (rec.last_record)
					release_batch();
			end
			if (sorted_valid && sorted_ready) begin
				if (sorted_due.size() == 0) begin
					$error("sorted word %h arrived with nothing expected", sorted);
					mismatches++;
				end else begin
					want = sorted_due.pop_front();
					compare_field("sorted_head", want.sorted_head, sorted.sorted_head);
					compare_field("sorted_tail", 64'(want.sorted_tail),
					              64'(sorted.sorted_tail));
					compare_field("sorted_tag", 64'(want.sorted_tag), 64'(sorted.sorted_tag));
					compare_field("final_out", 64'(want.final_out), 64'(sorted.final_out));
					words_checked++;
				end
			end
			words_due = sorted_due.size();
		end
	end

endmodule

// ===== tb/tb_record_exchange_sort_by_name.sv =====
// Testbench top: feeds record batches to the name sorter, idles both channels and gives the verdict.
`timescale 1ns / 100ps
module tb_record_exchange_sort_by_name;
	import resbn_pkg::*;

	localparam int unsigned RECORDS      = RECORDS_DEF;
	localparam int          RANDOM_WORDS = 280;
	// The quiet limit leaves ample room for the sort of a full batch and for stalls.
	localparam int          QUIET_LIMIT  = 3000;
	localparam int          DRAIN_CYCLES = 120;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} stall_mode_e;

	logic     clk;
	logic     arst_n;
	logic     rec_valid;
	logic     rec_ready;
	rec_in_t  rec;
	logic     sorted_valid;
	logic     sorted_ready;
	rec_out_t sorted;

	int mismatches;
	int words_due;
	int words_checked;

	int words_sent;
	int batches_sent;
	int overflow_batches;
	int batch_words;
	int burst_left;
	int random_goal;
	int quiet_cycles;

	// Recent keys, reused so that batches often hold equal keys.
	logic [71:0] key_pool [$];

	record_exchange_sort_by_name #(.RECORDS(RECORDS)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (rec_valid),
		.rec_ready    (rec_ready),
		.rec          (rec),
		.sorted_valid (sorted_valid),
		.sorted_ready (sorted_ready),
		.sorted       (sorted)
	);

	sort_order_monitor #(.RECORDS(RECORDS)) order_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (rec_valid),
		.rec_ready     (rec_ready),
		.rec           (rec),
		.sorted_valid  (sorted_valid),
		.sorted_ready  (sorted_ready),
		.sorted        (sorted),
		.mismatches    (mismatches),
		.words_due     (words_due),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Builds a zero-padded key from a name; only the first nine characters count.
	function automatic logic [71:0] name_key(input string name);
		logic [71:0] k;
		k = '0;
		for (int p = 0; p < name.len() && p < 9; p++)
			k[71 - 8 * p -: 8] = name[p];
		return k;
	endfunction

	// Draws a key. Half are short names over a tiny alphabet, so prefixes collide often
	// and the comparison has to reach deep into the key. The rest are raw 72-bit patterns,
	// repeats of recent keys, and keys built from all-zero or all-one halves.
	function automatic logic [71:0] random_key();
		logic [71:0] k;
		int          len;
		k = '0;
		case ($urandom_range(0, 9)) inside
			[0:1]: k = {$urandom, $urandom, 8'($urandom)};
			2: k = {{64{1'($urandom)}}, {8{1'($urandom)}}};
			[3:4]: begin
				if (key_pool.size() != 0)
					k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			end
			default: begin
				len = $urandom_range(0, 9);
				for (int p = 0; p < len; p++)
					k[71 - 8 * p -: 8] = ($urandom_range(0, 1) ? 8'h41 : 8'h61)
					                   + 8'($urandom_range(0, 3));
			end
		endcase
		key_pool.push_back(k);
		if (key_pool.size() > 16)
			void'(key_pool.pop_front());
		return k;
	endfunction

	// Sends one word. The sender works in bursts; before each burst it drops valid
	// for a random gap. The task is entered and left at a falling edge, so a word that
	// follows straight on keeps valid high without lowering it in between.
	task automatic send_record(input logic [71:0] key, input logic [2:0] tag,
	                           input logic last);
		rec_in_t w;
		w = '{key_head: key[71:8], key_tail: key[7:0], record_tag: tag, last_record: last};
		if (burst_left == 0) begin
			rec_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
		end
		burst_left--;
		rec       <= w;
		rec_valid <= 1'b1;
		do @(posedge clk); while (!rec_ready);
		@(negedge clk);
		words_sent++;
		batch_words++;
		if (last) begin
			batches_sent++;
			if (batch_words > RECORDS)
				overflow_batches++;
			batch_words = 0;
		end
	endtask

	task automatic send_random_batch(input int count);
		for (int i = 0; i < count; i++)
			send_record(random_key(), 3'($urandom_range(0, 7)), i == count - 1);
	endtask

	// The receiver switches between stall patterns, each held for a random stretch:
	// always ready, a coin toss, mostly stalled, and mostly ready.
	initial begin
		stall_mode_e mode;
		int          span;
		sorted_ready = 1'b0;
		mode         = READY_ALWAYS;
		span         = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				mode = stall_mode_e'($urandom_range(0, 3));
				span = $urandom_range(16, 96);
			end
			span--;
			case (mode)
				READY_ALWAYS: sorted_ready <= 1'b1;
				READY_COIN:   sorted_ready <= 1'($urandom);
				READY_SPARSE: sorted_ready <= ($urandom_range(0, 3) == 0);
				default:      sorted_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Watchdog: the run is declared hung once no word moves on either channel for too long.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((rec_valid && rec_ready) || (sorted_valid && sorted_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		rec_valid        = 1'b0;
		rec              = '0;
		words_sent       = 0;
		batches_sent     = 0;
		overflow_batches = 0;
		batch_words      = 0;
		burst_left       = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// A batch of one: the last flag comes with the very first word.
		send_record('0, 3'd5, 1'b1);

		// Extremes of both key parts, loaded in descending order so every pair swaps.
		send_record('1, 3'd7, 1'b0);
		send_record({64'hFFFF_FFFF_FFFF_FFFF, 8'h00}, 3'd0, 1'b0);
		send_record({64'h0, 8'hFF}, 3'd2, 1'b0);
		send_record('0, 3'd1, 1'b1);

		// Three equal keys must never be exchanged with each other. The fourth key
		// differs from them only in its ninth byte and has to move to the front.
		send_record(name_key("MARGARETE"), 3'd3, 1'b0);
		send_record(name_key("MARGARETE"), 3'd4, 1'b0);
		send_record(name_key("MARGARETE"), 3'd6, 1'b0);
		send_record(name_key("MARGARETA"), 3'd1, 1'b1);

		// Shared prefixes: the shorter name sorts first because its padding is zero.
		send_record(name_key("SMITHE"), 3'd2, 1'b0);
		send_record(name_key("SMITH"), 3'd6, 1'b0);
		send_record(name_key("SMIT"), 3'd7, 1'b1);

		// Overflow: two words past capacity are dropped. The second of them carries the
		// last flag and must still start the sort of the stored records.
		for (int i = 0; i < RECORDS + 2; i++)
			send_record({8'h5A - 8'(i), 64'h0}, 3'(i), i == RECORDS + 1);

		// Random batches, about one in ten over capacity.
		random_goal = words_sent + RANDOM_WORDS;
		while (words_sent < random_goal)
			send_random_batch(($urandom_range(0, 9) == 0) ? RECORDS + $urandom_range(1, 3)
			                                                 : $urandom_range(1, RECORDS));
		rec_valid <= 1'b0;

		// Wait for the last batch to drain, then watch a while for stray words.
		while (words_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sorted %0d batches (%0d past capacity) from %0d records; %0d words checked.",
		         batches_sent, overflow_batches, words_sent, words_checked);
		$display("Keys included shared-prefix names, repeated keys, raw patterns and extremes.");
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
